// ===== rtl/link_session_fsm_with_deframer_defines.svh =====
// ---------------------------------------------------------------------------
// Link session controller: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LINK_SESSION_FSM_WITH_DEFRAMER_DEFINES_SVH
`define LINK_SESSION_FSM_WITH_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define LSFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsfd check failed");

// next-cycle implication
`define LSFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsfd check failed");

`endif

// ===== rtl/lsfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Link session controller package
// Types, codes and constants shared by the front, queue, back and top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsfd_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned NUM_SLOTS   = 3;
  localparam int unsigned SLOT_IDX_W  = 2;
  localparam int unsigned HELLO_BYTES = 18;
  localparam int unsigned HELLO_IDX_W = 5;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_VERSION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 3'd5;

  localparam logic [31:0] RESP_TIMEOUT_RST = 32'd5000;
  localparam logic [31:0] RECONNECT_RST    = 32'd5000;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;

  localparam logic [2:0] SC_OFFLINE  = 3'd0;
  localparam logic [2:0] SC_IDLE     = 3'd1;
  localparam logic [2:0] SC_WAIT     = 3'd2;
  localparam logic [2:0] SC_ACCEPTED = 3'd3;
  localparam logic [2:0] SC_RUNNING  = 3'd4;

  typedef enum logic [4:0] {
    ST_OFFLINE  = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_WAIT     = 5'b00100,
    ST_ACCEPTED = 5'b01000,
    ST_RUNNING  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    EV_NET_UP    = 4'd0,
    EV_NET_DOWN  = 4'd1,
    EV_TRY       = 4'd2,
    EV_FAIL      = 4'd3,
    EV_CONNECTED = 4'd4,
    EV_LINK_DOWN = 4'd5,
    EV_ACCEPT    = 4'd6,
    EV_REJECT    = 4'd7,
    EV_TIMEOUT   = 4'd8,
    EV_HELLO     = 4'd9,
    EV_PAYLOAD   = 4'd10,
    EV_EMPTY     = 4'd11,
    EV_OVER      = 4'd12
  } event_t;

  typedef struct packed {
    logic        net_up;
    logic        link_up;
    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic        connect_ok;
    logic        init_sent;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic        end_of_packet;
    logic        close_link;
    logic [2:0]  session_state;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] response_timeout_ms;
    logic [31:0] reconnect_interval_ms;
    logic [63:0] device_id;
    logic [31:0] device_type;
    logic [31:0] device_version;
    logic [15:0] max_payload;
  } cfg_regs_t;

  typedef struct packed {
    out_item_t [NUM_SLOTS-1:0] slot;
    logic [SLOT_IDX_W-1:0]     count;
    logic                      hello;
  } cmd_t;

  function automatic logic [2:0] state_code(state_t s);
    logic [2:0] c;
    unique case (s)
      ST_OFFLINE:  c = SC_OFFLINE;
      ST_IDLE:     c = SC_IDLE;
      ST_WAIT:     c = SC_WAIT;
      ST_ACCEPTED: c = SC_ACCEPTED;
      ST_RUNNING:  c = SC_RUNNING;
      default:     c = SC_OFFLINE;
    endcase
    return c;
  endfunction

  function automatic out_item_t mk_result(event_t ev, logic [7:0] d, logic [15:0] len,
                                          logic eop, logic cl, logic [2:0] sc);
    out_item_t r;
    r.event_res      = ev;
    r.data_byte      = d;
    r.payload_length = len;
    r.end_of_packet  = eop;
    r.close_link     = cl;
    r.session_state  = sc;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/lsfd_front.sv =====
// ---------------------------------------------------------------------------
// Link session controller: front
// Accepts poll items, runs the session state machine and deframer, and
// queues a command describing the results of each poll that has any.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  lsfd_pkg::cfg_regs_t cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsfd_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output lsfd_pkg::cmd_t     push_cmd
);
  import lsfd_pkg::*;

  state_t      st_r, st_nxt;
  logic [16:0] fbs_r, fbs_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [31:0] last_att_r, last_att_nxt;
  logic [31:0] resp_mark_r, resp_mark_nxt;
  logic [16:0] fbs_inc;
  logic [31:0] since_att;
  logic [31:0] since_resp;
  logic [SLOT_IDX_W-1:0] n;
  cmd_t        cmd;
  logic        accept;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign since_att  = in_data.now_ms - last_att_r;
  assign since_resp = in_data.now_ms - resp_mark_r;
  assign fbs_inc    = fbs_r + 17'd1;

  always_comb begin
    st_nxt        = st_r;
    fbs_nxt       = fbs_r;
    flen_nxt      = flen_r;
    last_att_nxt  = last_att_r;
    resp_mark_nxt = resp_mark_r;
    cmd           = '0;
    n             = '0;

    if (!in_data.link_up &&
        (st_nxt == ST_WAIT || st_nxt == ST_ACCEPTED || st_nxt == ST_RUNNING)) begin
      st_nxt   = ST_IDLE;
      fbs_nxt  = '0;
      flen_nxt = '0;
      cmd.slot[n] = mk_result(EV_LINK_DOWN, 8'd0, 16'd0, 1'b0, 1'b0, SC_IDLE);
      n = n + 2'd1;
    end

    if (!in_data.net_up) begin
      if (st_nxt != ST_OFFLINE) begin
        st_nxt   = ST_OFFLINE;
        fbs_nxt  = '0;
        flen_nxt = '0;
        cmd.slot[n] = mk_result(EV_NET_DOWN, 8'd0, 16'd0, 1'b0, 1'b0, SC_OFFLINE);
        n = n + 2'd1;
      end
    end else if (st_nxt == ST_OFFLINE) begin
      st_nxt   = ST_IDLE;
      fbs_nxt  = '0;
      flen_nxt = '0;
      cmd.slot[n] = mk_result(EV_NET_UP, 8'd0, 16'd0, 1'b0, 1'b0, SC_IDLE);
      n = n + 2'd1;
    end

    unique case (st_nxt)
      ST_IDLE: begin
        if (since_att >= cfg.reconnect_interval_ms) begin
          cmd.slot[n] = mk_result(EV_TRY, 8'd0, 16'd0, 1'b0, 1'b0, SC_IDLE);
          n = n + 2'd1;
          if (!in_data.connect_ok) begin
            last_att_nxt = in_data.now_ms;
            cmd.slot[n] = mk_result(EV_FAIL, 8'd0, 16'd0, 1'b0, 1'b0, SC_IDLE);
            n = n + 2'd1;
          end else begin
            cmd.hello     = 1'b1;
            st_nxt        = ST_WAIT;
            resp_mark_nxt = in_data.now_ms;
            cmd.slot[n] = mk_result(EV_CONNECTED, 8'd0, 16'd0, 1'b0, 1'b0, SC_WAIT);
            n = n + 2'd1;
          end
        end
      end
      ST_WAIT: begin
        if (in_data.byte_valid) begin
          if (in_data.rx_byte == 8'd0) begin
            st_nxt = ST_ACCEPTED;
            cmd.slot[n] = mk_result(EV_ACCEPT, 8'd0, 16'd0, 1'b0, 1'b0, SC_ACCEPTED);
            n = n + 2'd1;
          end else begin
            st_nxt       = ST_IDLE;
            fbs_nxt      = '0;
            flen_nxt     = '0;
            last_att_nxt = in_data.now_ms;
            cmd.slot[n] = mk_result(EV_REJECT, in_data.rx_byte, 16'd0, 1'b0, 1'b1, SC_IDLE);
            n = n + 2'd1;
          end
        end else if (since_resp > cfg.response_timeout_ms) begin
          st_nxt       = ST_IDLE;
          fbs_nxt      = '0;
          flen_nxt     = '0;
          last_att_nxt = in_data.now_ms;
          cmd.slot[n] = mk_result(EV_TIMEOUT, 8'd0, 16'd0, 1'b0, 1'b1, SC_IDLE);
          n = n + 2'd1;
        end
      end
      ST_ACCEPTED: begin
        if (in_data.init_sent) begin
          st_nxt = ST_RUNNING;
        end
      end
      ST_RUNNING: begin
        if (in_data.byte_valid) begin
          resp_mark_nxt = in_data.now_ms;
          if (fbs_r == 17'd0) begin
            flen_nxt = {in_data.rx_byte, 8'h00};
            fbs_nxt  = 17'd1;
          end else if (fbs_r == 17'd1) begin
            flen_nxt = {flen_r[15:8], in_data.rx_byte};
            fbs_nxt  = 17'd2;
            if (flen_nxt == 16'd0) begin
              fbs_nxt = '0;
              cmd.slot[n] = mk_result(EV_EMPTY, 8'd0, 16'd0, 1'b1, 1'b0, SC_RUNNING);
              n = n + 2'd1;
            end else if (flen_nxt > cfg.max_payload) begin
              cmd.slot[n] = mk_result(EV_OVER, 8'd0, flen_nxt, 1'b0, 1'b0, SC_RUNNING);
              n = n + 2'd1;
            end
          end else begin
            if (fbs_inc >= ({1'b0, flen_r} + 17'd2)) begin
              cmd.slot[n] = mk_result(EV_PAYLOAD, in_data.rx_byte, flen_r, 1'b1, 1'b0,
                                      SC_RUNNING);
              fbs_nxt  = '0;
              flen_nxt = '0;
            end else begin
              cmd.slot[n] = mk_result(EV_PAYLOAD, in_data.rx_byte, flen_r, 1'b0, 1'b0,
                                      SC_RUNNING);
              fbs_nxt = fbs_inc;
            end
            n = n + 2'd1;
          end
        end else if (fbs_r != 17'd0 && since_resp > cfg.response_timeout_ms) begin
          st_nxt   = ST_IDLE;
          fbs_nxt  = '0;
          flen_nxt = '0;
          cmd.slot[n] = mk_result(EV_TIMEOUT, 8'd0, 16'd0, 1'b0, 1'b1, SC_IDLE);
          n = n + 2'd1;
          cmd.slot[n] = mk_result(EV_LINK_DOWN, 8'd0, 16'd0, 1'b0, 1'b0, SC_IDLE);
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase

    cmd.count = n;
  end

  assign push     = accept && (cmd.count != '0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_OFFLINE;
      fbs_r       <= '0;
      flen_r      <= '0;
      last_att_r  <= '0;
      resp_mark_r <= '0;
    end else if (accept) begin
      st_r        <= st_nxt;
      fbs_r       <= fbs_nxt;
      flen_r      <= flen_nxt;
      last_att_r  <= last_att_nxt;
      resp_mark_r <= resp_mark_nxt;
    end
  end

endmodule

// ===== rtl/lsfd_queue.sv =====
// ---------------------------------------------------------------------------
// Link session controller: command queue
// Short FIFO of poll commands between the front and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lsfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lsfd_pkg::cmd_t head_cmd
);
  import lsfd_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/lsfd_back.sv =====
// ---------------------------------------------------------------------------
// Link session controller: result sequencer
// Walks the queued command one result per cycle while the output is not
// stalled, inserting the hello burst, into a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lsfd_pkg::cfg_regs_t cfg,
  input  logic                head_valid,
  input  lsfd_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lsfd_pkg::out_item_t out_data
);
  import lsfd_pkg::*;

  logic [SLOT_IDX_W-1:0]  slot_idx_r, slot_idx_nxt;
  logic [HELLO_IDX_W-1:0] hb_idx_r, hb_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r;
  logic [8*HELLO_BYTES-1:0] hello_vec;
  logic [7:0]             hello_bytes [HELLO_BYTES];
  logic [SLOT_IDX_W-1:0]  final_idx;
  logic                   load;
  logic                   fire;
  logic                   in_hello;
  logic                   at_final;
  out_item_t              res;

  assign hello_vec = {cfg.device_id, cfg.device_type, cfg.device_version, cfg.max_payload};

  always_comb begin
    for (int i = 0; i < HELLO_BYTES; i++) begin
      hello_bytes[i] = hello_vec[8*(HELLO_BYTES-1-i) +: 8];
    end
  end

  assign final_idx = head_cmd.count - SLOT_IDX_W'(1);
  assign at_final  = (slot_idx_r == final_idx);
  assign in_hello  = head_cmd.hello && at_final && (hb_idx_r != HELLO_IDX_W'(HELLO_BYTES));
  assign load      = !out_valid_r || out_ready;
  assign fire      = head_valid && load;
  assign pop       = fire && !in_hello && at_final;

  always_comb begin
    if (in_hello) begin
      res = mk_result(EV_HELLO, hello_bytes[hb_idx_r], 16'd0, 1'b0, 1'b0, SC_IDLE);
    end else begin
      res      = head_cmd.slot[slot_idx_r];
      res.last = at_final;
    end
  end

  always_comb begin
    slot_idx_nxt = slot_idx_r;
    hb_idx_nxt   = hb_idx_r;
    if (fire) begin
      if (in_hello) begin
        hb_idx_nxt = hb_idx_r + HELLO_IDX_W'(1);
      end else if (at_final) begin
        slot_idx_nxt = '0;
        hb_idx_nxt   = '0;
      end else begin
        slot_idx_nxt = slot_idx_r + SLOT_IDX_W'(1);
      end
    end
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_idx_r  <= '0;
      hb_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_idx_r  <= slot_idx_nxt;
      hb_idx_r    <= hb_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/link_session_fsm_with_deframer.sv =====
// ---------------------------------------------------------------------------
// Link session controller with packet deframer
// Client session state machine with hello generation, timeouts and a
// 16-bit length-prefixed deframer; configuration registers live here.
// ---------------------------------------------------------------------------
// A poll item is taken every clock while the four-entry command queue has
// room; the front settles the new session state in the cycle it takes the
// item. Results leave one per clock while the receiver is ready, through a
// single registered output stage: a payload byte gives one result, most
// polls none to three, and a poll that opens a session 20 to 21 (the
// 18-byte hello burst). Configuration writes are registered and are
// accepted at any time.
`timescale 1ns / 1ps

module link_session_fsm_with_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lsfd_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lsfd_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lsfd_pkg::*;

`include "link_session_fsm_with_deframer_defines.svh"

  cfg_regs_t cfg_r;
  logic      q_full;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  logic      head_valid;
  cmd_t      head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_timeout_ms   <= RESP_TIMEOUT_RST;
      cfg_r.reconnect_interval_ms <= RECONNECT_RST;
      cfg_r.device_id             <= '0;
      cfg_r.device_type           <= '0;
      cfg_r.device_version        <= '0;
      cfg_r.max_payload           <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RESP_TIMEOUT:   cfg_r.response_timeout_ms   <= cfg_data[31:0];
        CFG_RECONNECT:      cfg_r.reconnect_interval_ms <= cfg_data[31:0];
        CFG_DEVICE_ID:      cfg_r.device_id             <= cfg_data;
        CFG_DEVICE_TYPE:    cfg_r.device_type           <= cfg_data[31:0];
        CFG_DEVICE_VERSION: cfg_r.device_version        <= cfg_data[31:0];
        CFG_MAX_PAYLOAD:    cfg_r.max_payload           <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  lsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lsfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `LSFD_ASSERT_IMPL(a_push_not_full, push, !q_full)
  `LSFD_ASSERT_IMPL(a_hello_mid_burst,
    out_valid && (out_data.event_res == EV_HELLO),
    !out_data.last && (out_data.session_state == SC_IDLE))
  `LSFD_ASSERT_IMPL(a_close_only_on_end,
    out_valid && out_data.close_link,
    (out_data.event_res == EV_REJECT) || (out_data.event_res == EV_TIMEOUT))
  `LSFD_ASSERT_NEXT(a_pop_moves_head, pop && !push && !q_full && head_valid,
    !q_full)

endmodule

// ===== tb/link_session_checker.sv =====
// ----------------------------------------------------------------------------
// Link session checker
// Watches the poll, result and register channels of the session controller.
// Keeps its own copy of the session state and registers, predicts the results
// of every poll transfer and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_session_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lsfd_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lsfd_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import lsfd_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [31:0] timeout_ms;
  logic [31:0] reconnect_ms;
  logic [63:0] dev_id;
  logic [31:0] dev_type;
  logic [31:0] dev_version;
  logic [15:0] max_len;

  logic [2:0]  sess_st;
  logic [31:0] last_try_ms;
  logic [31:0] resp_mark_ms;
  logic [16:0] frame_seen;
  logic [15:0] frame_len;

  out_item_t   poll_results[$];
  out_item_t   expected_results[$];
  int          mismatches;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %0s got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic add_result(input event_t ev, input logic [7:0] d, input logic [15:0] len,
                            input logic eop, input logic cl);
    out_item_t r;
    r.event_res      = ev;
    r.data_byte      = d;
    r.payload_length = len;
    r.end_of_packet  = eop;
    r.close_link     = cl;
    r.session_state  = sess_st;
    r.last           = 1'b0;
    poll_results.push_back(r);
  endtask

  task automatic drop_session(input logic [2:0] st);
    sess_st    = st;
    frame_seen = '0;
    frame_len  = '0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RESP_TIMEOUT:   timeout_ms   = val[31:0];
      CFG_RECONNECT:      reconnect_ms = val[31:0];
      CFG_DEVICE_ID:      dev_id       = val;
      CFG_DEVICE_TYPE:    dev_type     = val[31:0];
      CFG_DEVICE_VERSION: dev_version  = val[31:0];
      CFG_MAX_PAYLOAD:    max_len      = val[15:0];
      default: ;
    endcase
  endtask

  task automatic predict_poll(input in_item_t it);
    logic [31:0]  since_try;
    logic [31:0]  since_mark;
    logic [143:0] hello;
    out_item_t    r;
    int           i;

    poll_results.delete();
    if (sess_st > SC_RUNNING) drop_session(SC_OFFLINE);

    if (!it.link_up && sess_st > SC_IDLE) begin
      drop_session(SC_IDLE);
      add_result(EV_LINK_DOWN, 8'h00, 16'h0000, 1'b0, 1'b0);
    end
    if (!it.net_up) begin
      if (sess_st > SC_OFFLINE) begin
        drop_session(SC_OFFLINE);
        add_result(EV_NET_DOWN, 8'h00, 16'h0000, 1'b0, 1'b0);
      end
    end else if (sess_st == SC_OFFLINE) begin
      drop_session(SC_IDLE);
      add_result(EV_NET_UP, 8'h00, 16'h0000, 1'b0, 1'b0);
    end

    since_try  = it.now_ms - last_try_ms;
    since_mark = it.now_ms - resp_mark_ms;
    case (sess_st)
      SC_IDLE: begin
        if (since_try >= reconnect_ms) begin
          add_result(EV_TRY, 8'h00, 16'h0000, 1'b0, 1'b0);
          if (!it.connect_ok) begin
            last_try_ms = it.now_ms;
            add_result(EV_FAIL, 8'h00, 16'h0000, 1'b0, 1'b0);
          end else begin
            hello = {dev_id, dev_type, dev_version, max_len};
            for (i = 17; i >= 0; i--) begin
              add_result(EV_HELLO, hello[8*i +: 8], 16'h0000, 1'b0, 1'b0);
            end
            sess_st = SC_WAIT;
            add_result(EV_CONNECTED, 8'h00, 16'h0000, 1'b0, 1'b0);
            resp_mark_ms = it.now_ms;
          end
        end
      end
      SC_WAIT: begin
        if (it.byte_valid) begin
          if (it.rx_byte == 8'h00) begin
            sess_st = SC_ACCEPTED;
            add_result(EV_ACCEPT, 8'h00, 16'h0000, 1'b0, 1'b0);
          end else begin
            drop_session(SC_IDLE);
            last_try_ms = it.now_ms;
            add_result(EV_REJECT, it.rx_byte, 16'h0000, 1'b0, 1'b1);
          end
        end else if (since_mark > timeout_ms) begin
          drop_session(SC_IDLE);
          last_try_ms = it.now_ms;
          add_result(EV_TIMEOUT, 8'h00, 16'h0000, 1'b0, 1'b1);
        end
      end
      SC_ACCEPTED: begin
        if (it.init_sent) sess_st = SC_RUNNING;
      end
      SC_RUNNING: begin
        if (it.byte_valid) begin
          if (frame_seen == 17'd0) begin
            frame_len  = {it.rx_byte, 8'h00};
            frame_seen = 17'd1;
          end else if (frame_seen == 17'd1) begin
            frame_len  = {frame_len[15:8], it.rx_byte};
            frame_seen = 17'd2;
            if (frame_len == 16'h0000) begin
              add_result(EV_EMPTY, 8'h00, 16'h0000, 1'b1, 1'b0);
              frame_seen = 17'd0;
            end else if (frame_len > max_len) begin
              add_result(EV_OVER, 8'h00, frame_len, 1'b0, 1'b0);
            end
          end else begin
            frame_seen = frame_seen + 17'd1;
            if ({1'b0, frame_seen} >= {2'b00, frame_len} + 18'd2) begin
              add_result(EV_PAYLOAD, it.rx_byte, frame_len, 1'b1, 1'b0);
              frame_seen = 17'd0;
              frame_len  = 16'h0000;
            end else begin
              add_result(EV_PAYLOAD, it.rx_byte, frame_len, 1'b0, 1'b0);
            end
          end
          resp_mark_ms = it.now_ms;
        end else if (frame_seen != 17'd0 && since_mark > timeout_ms) begin
          drop_session(SC_IDLE);
          add_result(EV_TIMEOUT, 8'h00, 16'h0000, 1'b0, 1'b1);
          add_result(EV_LINK_DOWN, 8'h00, 16'h0000, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase

    if (poll_results.size() > 0) begin
      r = poll_results.pop_back();
      r.last = 1'b1;
      poll_results.push_back(r);
    end
    foreach (poll_results[i]) expected_results.push_back(poll_results[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report("result with nothing pending, event_res", 32'(got.event_res), 32'h0);
    end else begin
      want = expected_results.pop_front();
      if (got.event_res !== want.event_res)
        report("event_res", 32'(got.event_res), 32'(want.event_res));
      if (got.data_byte !== want.data_byte)
        report("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      if (got.payload_length !== want.payload_length)
        report("payload_length", 32'(got.payload_length), 32'(want.payload_length));
      if (got.end_of_packet !== want.end_of_packet)
        report("end_of_packet", 32'(got.end_of_packet), 32'(want.end_of_packet));
      if (got.close_link !== want.close_link)
        report("close_link", 32'(got.close_link), 32'(want.close_link));
      if (got.session_state !== want.session_state)
        report("session_state", 32'(got.session_state), 32'(want.session_state));
      if (got.last !== want.last)
        report("last", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms   = RESP_TIMEOUT_RST;
      reconnect_ms = RECONNECT_RST;
      dev_id       = '0;
      dev_type     = '0;
      dev_version  = '0;
      max_len      = MAX_PAYLOAD_RST;
      sess_st      = SC_OFFLINE;
      last_try_ms  = '0;
      resp_mark_ms = '0;
      frame_seen   = '0;
      frame_len    = '0;
      mismatches   = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_poll(in_data);
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Link session controller testbench
// Drives directed and random poll sequences through the session controller
// under several register settings, with random stalls on both channels and
// one long receiver hold-off; the checker predicts and compares all results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lsfd_pkg::*;

  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_POLLS   = 90;
  localparam int NUM_PHASES    = 5;
  localparam int LIMIT_NS      = 30_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  logic [31:0] clock_ms;
  logic [31:0] set_timeout;
  logic [31:0] set_reconnect;
  logic [15:0] set_max;
  int          polls_sent;
  bit          steady_in;
  int          hold_requests;

  link_session_fsm_with_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  link_session_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic rbit();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic logic [7:0] rbyte();
    logic [31:0] v;
    v = $urandom;
    return v[7:0];
  endfunction

  // receiver: random stalls, quiet stretches, and a long hold-off on request
  initial begin : sink
    int stall;
    int cycles;
    int holds_done;
    bit steady;
    out_ready <= 1'b0;
    stall = 0;
    cycles = 0;
    holds_done = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 64 == 0) steady = coin(25);
      if (hold_requests != holds_done) begin
        holds_done++;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !steady && coin(20)) begin
        stall = coin(90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic poll(input logic net, input logic link, input logic bv, input logic [7:0] rx,
                      input logic cok, input logic init, input logic [31:0] now_v);
    in_item_t it;
    int       gap;
    it.net_up     = net;
    it.link_up    = link;
    it.byte_valid = bv;
    it.rx_byte    = rx;
    it.connect_ok = cok;
    it.init_sent  = init;
    it.now_ms     = now_v;
    if (steady_in || coin(65)) gap = 0;
    else gap = coin(90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polls_sent++;
    if (polls_sent % 40 == 0) steady_in = coin(25);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] tmo, input logic [31:0] rcn,
                               input logic [63:0] id, input logic [31:0] dtype,
                               input logic [31:0] dver, input logic [15:0] maxp);
    logic [31:0] hi;
    hi = $urandom;
    write_reg(CFG_RESP_TIMEOUT, {hi, tmo});
    write_reg(CFG_RECONNECT, {~hi, rcn});
    write_reg(CFG_DEVICE_ID, id);
    write_reg(CFG_DEVICE_TYPE, {hi, dtype});
    write_reg(CFG_DEVICE_VERSION, {~hi, dver});
    write_reg(CFG_MAX_PAYLOAD, {hi, hi[15:0], maxp});
    cfg_valid <= 1'b0;
    set_timeout   = tmo;
    set_reconnect = rcn;
    set_max       = maxp;
  endtask

  task automatic send_rx(input logic [7:0] b);
    if (coin(15)) begin
      clock_ms += coin(50) ? 1 : 0;
      poll(1'b1, 1'b1, 1'b0, rbyte(), rbit(), rbit(), clock_ms);
    end
    poll(1'b1, 1'b1, 1'b1, b, rbit(), rbit(), clock_ms);
  endtask

  task automatic close_session();
    case ($urandom_range(0, 4))
      0: begin
        clock_ms += set_timeout + 32'd1;
        poll(1'b1, 1'b1, 1'b0, rbyte(), rbit(), rbit(), clock_ms);
      end
      1: poll(1'b1, 1'b0, rbit(), rbyte(), rbit(), rbit(), clock_ms);
      2: poll(1'b0, 1'b1, rbit(), rbyte(), rbit(), rbit(), clock_ms);
      3: poll(1'b0, 1'b0, rbit(), rbyte(), rbit(), rbit(), clock_ms);
      default: ;
    endcase
  endtask

  task automatic run_session();
    int   k;
    int   len;
    int   pk;
    int   npk;
    logic ok;

    poll(1'b0, rbit(), rbit(), rbyte(), rbit(), rbit(), clock_ms);
    ok = 1'b0;
    for (k = 0; k < 3 && !ok; k++) begin
      clock_ms += set_reconnect + $urandom_range(0, 2);
      ok = coin(85);
      poll(1'b1, 1'b1, rbit(), rbyte(), ok, rbit(), clock_ms);
    end
    if (!ok) return;

    if (coin(10)) begin
      repeat ($urandom_range(1, 3)) begin
        clock_ms += $urandom_range(0, 1);
        poll(1'b1, 1'b1, 1'b0, rbyte(), rbit(), rbit(), clock_ms);
      end
    end
    k = $urandom_range(0, 99);
    if (k < 75) begin
      poll(1'b1, 1'b1, 1'b1, 8'h00, rbit(), rbit(), clock_ms);
    end else if (k < 90) begin
      poll(1'b1, 1'b1, 1'b1, 8'($urandom_range(1, 255)), rbit(), rbit(), clock_ms);
      return;
    end else begin
      clock_ms += set_timeout + 32'd1;
      poll(1'b1, 1'b1, 1'b0, rbyte(), rbit(), rbit(), clock_ms);
      return;
    end

    repeat ($urandom_range(0, 2)) poll(1'b1, 1'b1, rbit(), rbyte(), rbit(), 1'b0, clock_ms);
    poll(1'b1, 1'b1, rbit(), rbyte(), rbit(), 1'b1, clock_ms);

    npk = $urandom_range(1, 4);
    for (pk = 0; pk < npk; pk++) begin
      len = $urandom_range(0, 6);
      if (set_max < 16 && coin(20)) len = set_max + $urandom_range(1, 3);
      send_rx(len[15:8]);
      send_rx(len[7:0]);
      for (k = 0; k < len; k++) begin
        if (coin(3)) begin
          close_session();
          return;
        end
        send_rx(rbyte());
      end
    end
    close_session();
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_RESP_TIMEOUT;
    cfg_data      <= '0;
    hold_requests <= 0;
    clock_ms   = '0;
    polls_sent = 0;
    steady_in  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // wrap-around intervals, zero timeout, zero payload limit
    load_settings(32'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h8000_0001, 16'd0);
    poll(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0000_0000);
    poll(1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFE);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFE);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFE);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFE);
    poll(1'b1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFE);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h01, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'hA5, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b1, 8'h80, 1'b0, 1'b0, 32'hFFFF_FFFD);
    poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0000_0005);
    poll(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0000_0005);
    poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0000_0006);
    clock_ms = 32'd6;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      case (ph)
        0: load_settings(32'd20, 32'd0, {$urandom, $urandom}, $urandom, $urandom, 16'd4);
        1: load_settings(32'hFFFF_FFFF, 32'd5, 64'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
        2: load_settings($urandom_range(0, 8), $urandom_range(0, 3), {$urandom, $urandom},
                         $urandom, $urandom, 16'($urandom_range(0, 6)));
        3: load_settings(RESP_TIMEOUT_RST, RECONNECT_RST, {$urandom, $urandom},
                         $urandom, $urandom, MAX_PAYLOAD_RST);
        default: load_settings(32'd1, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,
                               32'hFFFF_FFFF, 16'd2);
      endcase
      if (ph == 1) hold_requests <= hold_requests + 1;
      phase_end = polls_sent + PHASE_POLLS;
      while (polls_sent < phase_end) begin
        if (coin(85)) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 4)) begin
            clock_ms = coin(30) ? $urandom : clock_ms + $urandom_range(0, 3);
            poll(rbit(), rbit(), rbit(), rbyte(), rbit(), rbit(), clock_ms);
          end
        end
        if (coin(3)) quiesce();
      end
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
